// ===== rtl/core/gvcu_pkg.sv =====
// Shared types, codes and sizes for the vector command unit.
// No dependencies; the front, back and top-level files import this package.
`timescale 1ns / 1ps
package gvcu_pkg;

	localparam int NUM_REGS       = 32;
	localparam int WORD_W         = 32;
	localparam int REG_AW         = 5;
	localparam int ACC_W          = 50;
	localparam int PROD_W         = 49;
	localparam int NUM_SLOTS      = 11;
	localparam int QUEUE_DEPTH    = 2;
	localparam int FRAC_SHIFT_DEF = 12;

	localparam logic [2:0] KIND_RD_DATA = 3'd0;
	localparam logic [2:0] KIND_WR_DATA = 3'd1;
	localparam logic [2:0] KIND_RD_CTRL = 3'd2;
	localparam logic [2:0] KIND_WR_CTRL = 3'd3;
	localparam logic [2:0] KIND_COMMAND = 3'd4;

	localparam logic [2:0] CMD_NCLIP = 3'd0;
	localparam logic [2:0] CMD_MVMVA = 3'd1;
	localparam logic [2:0] CMD_OP    = 3'd2;
	localparam logic [2:0] CMD_SQR   = 3'd3;
	localparam logic [2:0] CMD_GPF   = 3'd4;
	localparam logic [2:0] CMD_GPL   = 3'd5;

	localparam logic [1:0] MAT_ZERO = 2'd3;
	localparam logic [1:0] VEC_ZERO = 2'd3;
	localparam logic [1:0] TR_REGS  = 2'd0;
	localparam logic [1:0] TR_BACK  = 2'd1;

	localparam logic signed [ACC_W-1:0] SAT_MAX = 50'sd32767;
	localparam logic signed [ACC_W-1:0] SAT_MIN = -50'sd32768;
	localparam logic [15:0] SAT_MAX_H = 16'h7FFF;
	localparam logic [15:0] SAT_MIN_H = 16'h8000;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_RD_DATA,
		OP_WR_DATA,
		OP_RD_CTRL,
		OP_WR_CTRL,
		OP_NCLIP,
		OP_MVMVA,
		OP_OP,
		OP_SQR,
		OP_GPF,
		OP_GPL
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [REG_AW-1:0] idx;
		logic [WORD_W-1:0] wval;
		logic [1:0]        ms;
		logic [1:0]        vs;
		logic [1:0]        ts;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDWAIT,
		ST_FETCH,
		ST_FLUSH,
		ST_MUL,
		ST_ACC,
		ST_ADDT,
		ST_WRITE
	} back_state_t;

endpackage

// ===== rtl/core/gvcu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gvcu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/gvcu_fifo.sv =====
// Small generic queue, register based, head word visible while not empty.
// No dependencies.
`timescale 1ns / 1ps
module gvcu_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push_ok, pop_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push_ok)
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop_ok)
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push_ok && !pop_ok)
				cnt_q <= cnt_q + 1'b1;
			else if (pop_ok && !push_ok)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok)
			mem[wptr_q] <= wdata;
	end

endmodule

// ===== rtl/core/gvcu_front.sv =====
// Front end: decodes each input beat into an operation and queues it.
// Depends on gvcu_pkg and gvcu_fifo.
`timescale 1ns / 1ps
module gvcu_front import gvcu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  access_kind,
	input  logic [4:0]  reg_index,
	input  logic [31:0] write_value,
	input  logic [2:0]  command_code,
	input  logic [1:0]  matrix_select,
	input  logic [1:0]  vector_select,
	input  logic [1:0]  translation_select,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_pop
);

	cmd_t dec;
	logic q_empty;

	always_comb begin
		dec.idx  = reg_index;
		dec.wval = write_value;
		dec.ms   = matrix_select;
		dec.vs   = vector_select;
		dec.ts   = translation_select;
		case (access_kind)
			KIND_RD_DATA: dec.op = OP_RD_DATA;
			KIND_WR_DATA: dec.op = OP_WR_DATA;
			KIND_RD_CTRL: dec.op = OP_RD_CTRL;
			KIND_WR_CTRL: dec.op = OP_WR_CTRL;
			KIND_COMMAND: begin
				case (command_code)
					CMD_NCLIP: dec.op = OP_NCLIP;
					CMD_MVMVA: dec.op = OP_MVMVA;
					CMD_OP:    dec.op = OP_OP;
					CMD_SQR:   dec.op = OP_SQR;
					CMD_GPF:   dec.op = OP_GPF;
					CMD_GPL:   dec.op = OP_GPL;
					default:   dec.op = OP_NOP;
				endcase
			end
			default: dec.op = OP_NOP;
		endcase
	end

	gvcu_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (dec),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd),
		.empty (q_empty)
	);

	assign cmd_valid = !q_empty;

endmodule

// ===== rtl/core/gvcu_back.sv =====
// Back end: register files and the sequencer that runs accesses and commands
// on one shared multiplier. Depends on gvcu_pkg and gvcu_ram.
`timescale 1ns / 1ps
module gvcu_back import gvcu_pkg::*; #(
	parameter int FRACTION_SHIFT = FRAC_SHIFT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_push,
	output logic [WORD_W-1:0] res_data
);

	back_state_t state_q, state_d;
	cmd_t        cur_q;

	logic [WORD_W-1:0] w_q [NUM_SLOTS];
	logic [3:0]        i_q, rd_slot_q;
	logic              rd_pend_q, rd_ctrl_q, rd_valid_q;
	logic [1:0]        r_q;
	logic [2:0]        k_q, j_q;
	logic signed [PROD_W-1:0] p_q;
	logic              neg_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  mac_q [3];
	logic [NUM_REGS-1:0] dvalid_q, cvalid_q;

	logic              d_we, c_we, rd_is_ctrl;
	logic [REG_AW-1:0] d_waddr, c_waddr, d_raddr, c_raddr;
	logic [WORD_W-1:0] d_wdata, c_wdata, d_rdata, c_rdata, rd_word;
	logic              start;

	gvcu_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_dram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	gvcu_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_cram (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);

	// entries never written since reset read as zero
	assign rd_word = !rd_valid_q ? '0 : (rd_ctrl_q ? c_rdata : d_rdata);
	assign start   = cmd_valid && !res_full;

	// per-command sequencing figures
	logic [3:0] n_fetch;
	logic [2:0] n_terms, n_writes;
	logic [1:0] last_row;
	logic       has_addt, is_interp;

	always_comb begin
		n_fetch   = 4'd4;
		n_terms   = 3'd1;
		n_writes  = 3'd6;
		last_row  = 2'd2;
		has_addt  = 1'b0;
		is_interp = 1'b0;
		case (cur_q.op)
			OP_NCLIP: begin
				n_fetch  = 4'd6;
				n_terms  = 3'd6;
				n_writes = 3'd1;
				last_row = 2'd0;
			end
			OP_MVMVA, OP_OP: begin
				n_fetch  = 4'd11;
				n_terms  = 3'd3;
				has_addt = 1'b1;
			end
			OP_GPL: begin
				has_addt  = 1'b1;
				is_interp = 1'b1;
			end
			default: is_interp = 1'b1;
		endcase
	end

	// operand word fetch order
	logic              f_ctrl;
	logic [REG_AW-1:0] f_addr;

	always_comb begin
		f_ctrl = 1'b0;
		f_addr = '0;
		case (cur_q.op)
			OP_NCLIP: f_addr = REG_AW'(5'd12 + 5'(i_q));
			OP_MVMVA, OP_OP: begin
				if (i_q < 4'd5) begin
					f_ctrl = 1'b1;
					if (cur_q.op == OP_OP)
						f_addr = REG_AW'(i_q);
					else
						f_addr = REG_AW'({cur_q.ms, 3'b000} + 5'(i_q));
				end else if (i_q < 4'd8) begin
					if (cur_q.op == OP_OP)
						f_addr = REG_AW'(5'd4 + 5'(i_q));
					else if (i_q == 4'd6)
						f_addr = REG_AW'({3'b000, cur_q.vs} + 5'd4);
					else
						f_addr = REG_AW'({3'b000, cur_q.vs});
				end else begin
					f_ctrl = 1'b1;
					if (cur_q.op == OP_MVMVA && cur_q.ts == TR_BACK)
						f_addr = (i_q == 4'd8) ? 5'd13 : 5'd14;
					else
						f_addr = REG_AW'(5'(i_q) - 5'd3);
				end
			end
			default: f_addr = REG_AW'(5'd8 + 5'(i_q));
		endcase
	end

	// operand selection for the current term
	logic [3:0]  mi;
	logic [WORD_W-1:0] mw;
	logic signed [15:0] m_val, v_val, ir_val, op_a;
	logic signed [32:0] op_b, t_val;
	logic               op_neg;
	logic signed [ACC_W-1:0] addend;

	assign mi = 4'(r_q) * 4'd3 + 4'(k_q);
	assign mw = w_q[mi >> 1];

	always_comb begin
		m_val = mi[0] ? mw[31:16] : mw[15:0];
		if (cur_q.op == OP_MVMVA && cur_q.ms == MAT_ZERO)
			m_val = '0;

		v_val = '0;
		if (cur_q.op == OP_OP) begin
			case (k_q)
				3'd0:    v_val = w_q[5][15:0];
				3'd1:    v_val = w_q[6][15:0];
				default: v_val = w_q[7][15:0];
			endcase
		end else if (cur_q.vs != VEC_ZERO) begin
			case (k_q)
				3'd0:    v_val = w_q[5][15:0];
				3'd1:    v_val = w_q[5][31:16];
				default: v_val = w_q[6][15:0];
			endcase
		end

		case (r_q)
			2'd0:    ir_val = w_q[1][15:0];
			2'd1:    ir_val = w_q[2][15:0];
			default: ir_val = w_q[3][15:0];
		endcase

		t_val = '0;
		if (cur_q.op == OP_OP || cur_q.ts == TR_REGS) begin
			case (r_q)
				2'd0:    t_val = 33'($signed(w_q[8]));
				2'd1:    t_val = 33'($signed(w_q[9]));
				default: t_val = 33'($signed(w_q[10]));
			endcase
		end else if (cur_q.ts == TR_BACK) begin
			case (r_q)
				2'd0:    t_val = {17'd0, w_q[8][15:0]};
				2'd1:    t_val = {17'd0, w_q[8][31:16]};
				default: t_val = {17'd0, w_q[9][15:0]};
			endcase
		end

		op_neg = 1'b0;
		op_a   = m_val;
		op_b   = 33'(v_val);
		case (cur_q.op)
			OP_NCLIP: begin
				op_neg = (k_q >= 3'd3);
				case (k_q)
					3'd0: begin op_a = w_q[0][15:0]; op_b = 33'($signed(w_q[3][15:0])); end
					3'd1: begin op_a = w_q[2][15:0]; op_b = 33'($signed(w_q[5][15:0])); end
					3'd2: begin op_a = w_q[4][15:0]; op_b = 33'($signed(w_q[1][15:0])); end
					3'd3: begin op_a = w_q[0][15:0]; op_b = 33'($signed(w_q[5][15:0])); end
					3'd4: begin op_a = w_q[2][15:0]; op_b = 33'($signed(w_q[1][15:0])); end
					default: begin
						op_a = w_q[4][15:0];
						op_b = 33'($signed(w_q[3][15:0]));
					end
				endcase
			end
			OP_MVMVA, OP_OP: begin
				op_a = m_val;
				op_b = 33'(v_val);
			end
			OP_SQR: begin
				op_a = ir_val;
				op_b = 33'(ir_val);
			end
			default: begin
				op_a = ir_val;
				op_b = 33'($signed(w_q[0]));
			end
		endcase

		if (is_interp)
			addend = ACC_W'(ir_val) <<< FRACTION_SHIFT;
		else
			addend = ACC_W'(t_val) <<< FRACTION_SHIFT;
	end

	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_sum;
	assign prod    = PROD_W'(op_a) * PROD_W'(op_b);
	assign acc_sum = neg_q ? acc_q - ACC_W'(p_q) : acc_q + ACC_W'(p_q);

	// write-back selection
	function automatic logic [15:0] sat16(input logic signed [ACC_W-1:0] v);
		if (v > SAT_MAX)
			return SAT_MAX_H;
		else if (v < SAT_MIN)
			return SAT_MIN_H;
		return v[15:0];
	endfunction

	logic [1:0]              wr_row;
	logic signed [ACC_W-1:0] wr_mac, wr_sh;
	logic [REG_AW-1:0]       wb_addr;
	logic [WORD_W-1:0]       wb_data;

	assign wr_row = j_q[2:1];
	assign wr_mac = mac_q[wr_row];
	assign wr_sh  = wr_mac >>> FRACTION_SHIFT;

	always_comb begin
		if (cur_q.op == OP_NCLIP) begin
			wb_addr = 5'd24;
			wb_data = wr_mac[31:0];
		end else if (!j_q[0]) begin
			wb_addr = REG_AW'(5'd25 + 5'(wr_row));
			wb_data = is_interp ? wr_sh[31:0] : wr_mac[31:0];
		end else begin
			if (cur_q.op == OP_GPF || cur_q.op == OP_GPL)
				wb_addr = REG_AW'(5'd22 + 5'(wr_row));
			else
				wb_addr = REG_AW'(5'd9 + 5'(wr_row));
			if (is_interp)
				wb_data = {16'd0, sat16(wr_sh)};
			else
				wb_data = {16'd0, sat16(ACC_W'($signed(wr_sh[31:0])))};
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd.op)
						OP_RD_DATA, OP_RD_CTRL: state_d = ST_RDWAIT;
						OP_NCLIP, OP_MVMVA, OP_OP, OP_SQR, OP_GPF, OP_GPL:
							state_d = ST_FETCH;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RDWAIT: state_d = ST_IDLE;
			ST_FETCH:  if (i_q == n_fetch - 4'd1) state_d = ST_FLUSH;
			ST_FLUSH:  state_d = ST_MUL;
			ST_MUL:    state_d = ST_ACC;
			ST_ACC: begin
				if (k_q != n_terms - 3'd1)
					state_d = ST_MUL;
				else if (has_addt)
					state_d = ST_ADDT;
				else if (r_q == last_row)
					state_d = ST_WRITE;
				else
					state_d = ST_MUL;
			end
			ST_ADDT:  state_d = (r_q == last_row) ? ST_WRITE : ST_MUL;
			ST_WRITE: if (j_q == n_writes - 3'd1) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		res_data   = '0;
		d_we       = 1'b0;
		c_we       = 1'b0;
		d_waddr    = cmd.idx;
		c_waddr    = cmd.idx;
		d_wdata    = cmd.wval;
		c_wdata    = cmd.wval;
		d_raddr    = cmd.idx;
		c_raddr    = cmd.idx;
		rd_is_ctrl = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_WR_DATA: begin d_we = 1'b1; res_push = 1'b1; end
						OP_WR_CTRL: begin c_we = 1'b1; res_push = 1'b1; end
						OP_RD_CTRL: rd_is_ctrl = 1'b1;
						OP_NOP:     res_push = 1'b1;
						default:    ;
					endcase
				end
			end
			ST_RDWAIT: begin
				res_push = 1'b1;
				res_data = rd_word;
			end
			ST_FETCH: begin
				rd_is_ctrl = f_ctrl;
				d_raddr    = f_addr;
				c_raddr    = f_addr;
			end
			ST_WRITE: begin
				d_we     = 1'b1;
				d_waddr  = wb_addr;
				d_wdata  = wb_data;
				res_push = (j_q == n_writes - 3'd1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dvalid_q  <= '0;
			cvalid_q  <= '0;
			rd_pend_q <= 1'b0;
			i_q       <= '0;
			r_q       <= '0;
			k_q       <= '0;
			j_q       <= '0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= (state_q == ST_FETCH);
			if (d_we)
				dvalid_q[d_waddr] <= 1'b1;
			if (c_we)
				cvalid_q[c_waddr] <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					r_q <= '0;
					k_q <= '0;
					j_q <= '0;
				end
				ST_FETCH: i_q <= i_q + 4'd1;
				ST_ACC: begin
					if (k_q != n_terms - 3'd1)
						k_q <= k_q + 3'd1;
					else if (!has_addt) begin
						k_q <= '0;
						r_q <= r_q + 2'd1;
					end
				end
				ST_ADDT: begin
					k_q <= '0;
					r_q <= r_q + 2'd1;
				end
				ST_WRITE: j_q <= j_q + 3'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_ctrl_q  <= rd_is_ctrl;
		rd_valid_q <= rd_is_ctrl ? cvalid_q[c_raddr] : dvalid_q[d_raddr];
		rd_slot_q  <= i_q;
		if (rd_pend_q)
			w_q[rd_slot_q] <= rd_word;
		case (state_q)
			ST_IDLE: begin
				if (start)
					cur_q <= cmd;
				acc_q <= '0;
			end
			ST_MUL: begin
				p_q   <= prod;
				neg_q <= op_neg;
			end
			ST_ACC: begin
				if (k_q == n_terms - 3'd1 && !has_addt) begin
					mac_q[r_q] <= acc_sum;
					acc_q      <= '0;
				end else
					acc_q <= acc_sum;
			end
			ST_ADDT: begin
				mac_q[r_q] <= acc_q + addend;
				acc_q      <= '0;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/gte_vector_command_unit.sv =====
// Top level of the vector command unit: front decode queue, back sequencer,
// result queue. Depends on gvcu_pkg, gvcu_front, gvcu_back, gvcu_fifo.
//
//  channel  | handshake        | beat contents
//  ---------+------------------+----------------------------------------------
//  input    | push / full      | access_kind, reg_index, write_value, command
//           |                  | code, matrix/vector/translation select
//  result   | pop / empty      | read_value
//
// Register writes and unknown codes finish in the back end's idle state, reads pass through a read-wait state.
// Commands run on one shared multiplier, each product passing through a multiply
// state and an accumulate state, after a fetch of their operand words one per
// cycle from the register RAM.
// Reset clears all registers at once through per-entry valid bits.
// A two-beat queue on each side lets input and result sides stall separately.
`timescale 1ns / 1ps
module gte_vector_command_unit import gvcu_pkg::*; #(
	parameter int FRACTION_SHIFT = FRAC_SHIFT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  access_kind,
	input  logic [4:0]  reg_index,
	input  logic [31:0] write_value,
	input  logic [2:0]  command_code,
	input  logic [1:0]  matrix_select,
	input  logic [1:0]  vector_select,
	input  logic [1:0]  translation_select,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] read_value
);

	logic              cmd_valid, cmd_pop;
	cmd_t              cmd;
	logic              res_full, res_push;
	logic [WORD_W-1:0] res_data;

	gvcu_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.access_kind       (access_kind),
		.reg_index         (reg_index),
		.write_value       (write_value),
		.command_code      (command_code),
		.matrix_select     (matrix_select),
		.vector_select     (vector_select),
		.translation_select(translation_select),
		.cmd_valid         (cmd_valid),
		.cmd               (cmd),
		.cmd_pop           (cmd_pop)
	);

	gvcu_back #(.FRACTION_SHIFT(FRACTION_SHIFT)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_data)
	);

	gvcu_fifo #(.WIDTH(WORD_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_data),
		.full  (res_full),
		.pop   (pop),
		.rdata (read_value),
		.empty (empty)
	);

endmodule
